### rtl/tlv8x_pkg.sv
`default_nettype none

package tlv8x_pkg;

  // parse position inside the current item
  typedef enum logic [2:0] {
    PH_TYPE = 3'b001,
    PH_LEN  = 3'b010,
    PH_VAL  = 3'b100
  } phase_t;

  // scan status reported with done_res
  typedef enum logic [1:0] {
    ST_FOUND    = 2'd0,
    ST_NOTFOUND = 2'd1,
    ST_TRUNC    = 2'd2
  } status_t;

  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  // one result item
  typedef struct packed {
    logic [7:0]  value_byte;
    logic        value_valid;
    logic        done_res;
    logic [1:0]  scan_status;
    logic [15:0] total_length;
  } res_t;

endpackage

`default_nettype wire

### rtl/tlv8x_in_if.sv
`default_nettype none

interface tlv8x_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, data_byte, last_byte, input ready);
  modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

`default_nettype wire

### rtl/tlv8x_out_if.sv
`default_nettype none

interface tlv8x_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  value_byte;
  logic        value_valid;
  logic        done_res;
  logic [1:0]  scan_status;
  logic [15:0] total_length;

  modport source (output valid, value_byte, value_valid, done_res, scan_status,
                  total_length, input ready);
  modport sink   (input valid, value_byte, value_valid, done_res, scan_status,
                  total_length, output ready);
endinterface

`default_nettype wire

### rtl/tlv8x_scan_core.sv
`default_nettype none

module tlv8x_scan_core
  import tlv8x_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  input  wire logic       xfer,
  input  wire logic [7:0] data_byte,
  input  wire logic       last_byte,
  output res_t            res
);

  logic [7:0]  target_type_r;
  phase_t      phase_r, phase_nxt;
  logic [7:0]  bytes_left_r, bytes_left_nxt;
  logic        match_r, match_nxt;
  logic        run_r, run_nxt;
  logic        finished_r, finished_nxt;
  logic [15:0] count_r, count_nxt;

  logic [7:0]  bl_dec;
  logic        done;
  status_t     status;

  assign bl_dec = bytes_left_r - 8'd1;

  // per-byte parse decision
  always_comb begin
    phase_nxt      = phase_r;
    bytes_left_nxt = bytes_left_r;
    match_nxt      = match_r;
    run_nxt        = run_r;
    finished_nxt   = finished_r;
    count_nxt      = count_r;
    done           = 1'b0;
    status         = ST_FOUND;
    res            = '0;

    if (!finished_r) begin
      case (phase_r)
        PH_LEN: begin
          bytes_left_nxt = data_byte;
          if (data_byte == 8'd0) begin
            phase_nxt = PH_TYPE;
            if (last_byte) begin
              done   = 1'b1;
              status = (count_r != 16'd0) ? ST_FOUND : ST_NOTFOUND;
            end
          end else begin
            phase_nxt = PH_VAL;
            if (last_byte) begin
              done   = 1'b1;
              status = ST_TRUNC;
            end
          end
        end
        PH_VAL: begin
          if (match_r) begin
            res.value_valid = 1'b1;
            res.value_byte  = data_byte;
            if (count_r != COUNT_MAX) begin
              count_nxt = count_r + 16'd1;
            end
          end
          bytes_left_nxt = bl_dec;
          if (bl_dec == 8'd0) begin
            phase_nxt = PH_TYPE;
            if (last_byte) begin
              done   = 1'b1;
              status = (count_nxt != 16'd0) ? ST_FOUND : ST_NOTFOUND;
            end
          end else if (last_byte) begin
            done   = 1'b1;
            status = ST_TRUNC;
          end
        end
        PH_TYPE: begin
          if (run_r && (data_byte != target_type_r)) begin
            // different type after a matched run ends the scan
            done   = 1'b1;
            status = (count_r != 16'd0) ? ST_FOUND : ST_NOTFOUND;
          end else begin
            match_nxt = (data_byte == target_type_r);
            if (data_byte == target_type_r) begin
              run_nxt = 1'b1;
            end
            phase_nxt = PH_LEN;
            if (last_byte) begin
              done   = 1'b1;
              status = ST_TRUNC;
            end
          end
        end
        default: begin
          phase_nxt = PH_TYPE;
        end
      endcase

      if (done) begin
        res.done_res     = 1'b1;
        res.scan_status  = status;
        res.total_length = count_nxt;
        finished_nxt     = 1'b1;
      end
    end

    // end of buffer clears the scan for the next one
    if (last_byte && (finished_r || done)) begin
      phase_nxt      = PH_TYPE;
      bytes_left_nxt = 8'd0;
      match_nxt      = 1'b0;
      run_nxt        = 1'b0;
      finished_nxt   = 1'b0;
      count_nxt      = 16'd0;
    end
  end

  // scan state and target register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_type_r <= 8'd0;
      phase_r       <= PH_TYPE;
      bytes_left_r  <= 8'd0;
      match_r       <= 1'b0;
      run_r         <= 1'b0;
      finished_r    <= 1'b0;
      count_r       <= 16'd0;
    end else begin
      if (cfg_we) begin
        target_type_r <= cfg_wdata;
      end
      if (xfer) begin
        phase_r      <= phase_nxt;
        bytes_left_r <= bytes_left_nxt;
        match_r      <= match_nxt;
        run_r        <= run_nxt;
        finished_r   <= finished_nxt;
        count_r      <= count_nxt;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/tlv8_item_extractor.sv
// a result is registered when its byte transfers (into the skid on a stall)
// throughput: one byte per cycle while the skid entry is empty
// a two-entry output stage (result register plus skid) keeps input flowing
// reset: synchronous active-low rst_n clears the scan state, target_type
// and the output stage; the block is ready in the cycle after reset

`default_nettype none

module tlv8_item_extractor
  import tlv8x_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       cfg_we,
  input  wire logic [7:0] cfg_wdata,
  tlv8x_in_if.sink        in_ch,
  tlv8x_out_if.source     out_ch
);

  logic in_xfer;
  logic out_xfer;
  res_t res;
  res_t main_r;
  res_t skid_r;
  logic main_valid_r;
  logic skid_valid_r;
  logic push;

  assign in_ch.ready = !skid_valid_r;
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign out_xfer    = main_valid_r && out_ch.ready;
  assign push        = in_xfer && (res.value_valid || res.done_res);

  tlv8x_scan_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .xfer      (in_xfer),
    .data_byte (in_ch.data_byte),
    .last_byte (in_ch.last_byte),
    .res       (res)
  );

  // output control: result register backed by one skid entry
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (out_xfer) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !out_xfer) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (out_xfer) begin
      main_valid_r <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_xfer) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_valid_r && !out_xfer) begin
        skid_r <= res;
      end else begin
        main_r <= res;
      end
    end
  end

  assign out_ch.valid        = main_valid_r;
  assign out_ch.value_byte   = main_r.value_byte;
  assign out_ch.value_valid  = main_r.value_valid;
  assign out_ch.done_res     = main_r.done_res;
  assign out_ch.scan_status  = main_r.scan_status;
  assign out_ch.total_length = main_r.total_length;

endmodule

`default_nettype wire

### test/tb.sv
`timescale 1ns / 100ps

module tb;
  import tlv8x_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int PHASE_BYTES = 270;

  typedef enum {ROW_BYTE, ROW_CFG} row_kind_t;
  typedef enum {CHK_PRED, CHK_NONE, CHK_RES} chk_t;

  typedef struct {
    row_kind_t  kind;
    logic [7:0] data;
    logic       last;
    chk_t       chk;
    res_t       exp;
  } stim_row_t;

  logic       clk;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  tlv8x_in_if  in_ch();
  tlv8x_out_if out_ch();

  tlv8_item_extractor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  // predicted parser state
  logic [7:0]  p_target;
  phase_t      p_phase;
  logic [7:0]  p_left;
  logic        p_match;
  logic        p_run;
  logic        p_finished;
  logic [15:0] p_count;

  res_t        due_results[$];
  stim_row_t   directed_rows[$];
  logic [7:0]  buf_q[$];

  // tag carried with each byte transfer
  chk_t        cur_chk;
  res_t        cur_exp;

  bit          allow_idle;
  int          fail_count;
  int          cycle_count;
  int          stall_left;

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // cycle counter and timeout
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb failed");
      $finish;
    end
  end

  function automatic void clear_scan();
    p_phase    = PH_TYPE;
    p_left     = 8'd0;
    p_match    = 1'b0;
    p_run      = 1'b0;
    p_finished = 1'b0;
    p_count    = 16'd0;
  endfunction

  function automatic res_t mk_res(input logic [7:0] v, input logic vv, input logic d,
                                  input status_t st, input logic [15:0] tot);
    res_t r;
    r.value_byte   = v;
    r.value_valid  = vv;
    r.done_res     = d;
    r.scan_status  = st;
    r.total_length = tot;
    return r;
  endfunction

  // one byte through the tlv scan, returns 1 when a result comes out
  function automatic bit parse_byte(input logic [7:0] b, input logic lst, output res_t r);
    bit      done;
    status_t st;
    r    = '0;
    done = 1'b0;
    st   = ST_FOUND;
    if (p_finished) begin
      if (lst) clear_scan();
      return 1'b0;
    end
    case (p_phase)
      PH_LEN: begin
        p_left = b;
        if (b == 8'd0) begin
          p_phase = PH_TYPE;
          if (lst) begin
            done = 1'b1;
            st   = (p_count != 16'd0) ? ST_FOUND : ST_NOTFOUND;
          end
        end else begin
          p_phase = PH_VAL;
          if (lst) begin
            done = 1'b1;
            st   = ST_TRUNC;
          end
        end
      end
      PH_VAL: begin
        if (p_match) begin
          r.value_valid = 1'b1;
          r.value_byte  = b;
          if (p_count != COUNT_MAX) p_count = p_count + 16'd1;
        end
        p_left = p_left - 8'd1;
        if (p_left == 8'd0) begin
          p_phase = PH_TYPE;
          if (lst) begin
            done = 1'b1;
            st   = (p_count != 16'd0) ? ST_FOUND : ST_NOTFOUND;
          end
        end else if (lst) begin
          done = 1'b1;
          st   = ST_TRUNC;
        end
      end
      default: begin
        // a foreign type after a match closes the scan
        if (p_run && b != p_target) begin
          done = 1'b1;
          st   = (p_count != 16'd0) ? ST_FOUND : ST_NOTFOUND;
        end else begin
          p_match = (b == p_target);
          if (p_match) p_run = 1'b1;
          p_phase = PH_LEN;
          if (lst) begin
            done = 1'b1;
            st   = ST_TRUNC;
          end
        end
      end
    endcase
    if (done) begin
      r.done_res     = 1'b1;
      r.scan_status  = st;
      r.total_length = p_count;
      if (lst) clear_scan();
      else p_finished = 1'b1;
    end
    return r.value_valid || r.done_res;
  endfunction

  task automatic report_mismatch(input string msg);
    fail_count++;
    if (fail_count <= 50) $display("mismatch at cycle %0d: %s", cycle_count, msg);
  endtask

  // result check, then prediction for the byte that transfers
  always @(posedge clk) begin : scoreboard
    res_t e;
    res_t r;
    bit   has;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (due_results.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = due_results.pop_front();
        if (out_ch.value_byte !== e.value_byte)
          report_mismatch($sformatf("value_byte %h, expected %h",
                                    out_ch.value_byte, e.value_byte));
        if (out_ch.value_valid !== e.value_valid)
          report_mismatch($sformatf("value_valid %b, expected %b",
                                    out_ch.value_valid, e.value_valid));
        if (out_ch.done_res !== e.done_res)
          report_mismatch($sformatf("done_res %b, expected %b",
                                    out_ch.done_res, e.done_res));
        if (out_ch.scan_status !== e.scan_status)
          report_mismatch($sformatf("scan_status %0d, expected %0d",
                                    out_ch.scan_status, e.scan_status));
        if (out_ch.total_length !== e.total_length)
          report_mismatch($sformatf("total_length %0d, expected %0d",
                                    out_ch.total_length, e.total_length));
      end
    end
    if (rst_n && in_ch.valid && in_ch.ready) begin
      has = parse_byte(in_ch.data_byte, in_ch.last_byte, r);
      case (cur_chk)
        CHK_PRED: if (has) due_results.push_back(r);
        CHK_RES:  due_results.push_back(cur_exp);
        default: ;
      endcase
    end
  end

  // result side back-pressure in bursts
  initial begin
    out_ch.ready = 1'b1;
    stall_left   = 0;
    forever begin
      @(posedge clk);
      if (!allow_idle) begin
        out_ch.ready <= 1'b1;
        stall_left   <= 0;
      end else if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        out_ch.ready <= (stall_left == 1);
      end else if ($urandom_range(0, 7) == 0) begin
        stall_left   <= $urandom_range(1, 19);
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic send_byte(input logic [7:0] d, input logic l, input chk_t chk,
                           input res_t e);
    int gap;
    if (allow_idle && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 19);
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.data_byte <= d;
    in_ch.last_byte <= l;
    cur_chk         <= chk;
    cur_exp         <= e;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  // register write once the block has drained
  task automatic write_target(input logic [7:0] v);
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    p_target  = v;
  endtask

  task automatic add_row(input row_kind_t k, input logic [7:0] d, input logic l,
                         input chk_t chk, input res_t e);
    stim_row_t row;
    row.kind = k;
    row.data = d;
    row.last = l;
    row.chk  = chk;
    row.exp  = e;
    directed_rows.push_back(row);
  endtask

  // random buffer: mostly well-formed items, some noise and truncation
  task automatic make_buffer();
    int         kind;
    int         n_items;
    int         len;
    int         pick;
    int         cut;
    logic [7:0] ty;
    buf_q.delete();
    kind = $urandom_range(0, 9);
    if (kind == 0) begin
      len = $urandom_range(1, 12);
      repeat (len) buf_q.push_back(8'($urandom_range(0, 255)));
    end else begin
      n_items = $urandom_range(1, 6);
      repeat (n_items) begin
        case ($urandom_range(0, 3))
          0, 1:    ty = p_target;
          2:       ty = p_target ^ (8'h01 << $urandom_range(0, 7));
          default: ty = 8'($urandom_range(0, 255));
        endcase
        pick = $urandom_range(0, 39);
        if (pick == 0) len = 255;
        else if (pick == 1) len = $urandom_range(0, 255);
        else if (pick < 8) len = 0;
        else len = $urandom_range(1, 8);
        buf_q.push_back(ty);
        buf_q.push_back(8'(len));
        repeat (len) buf_q.push_back(8'($urandom_range(0, 255)));
      end
      if (kind == 1) begin
        cut = $urandom_range(1, buf_q.size());
        while (buf_q.size() > cut) void'(buf_q.pop_back());
      end
    end
  endtask

  task automatic send_buffer(input int mid);
    for (int i = 0; i < buf_q.size(); i++) begin
      if (i == mid) write_target(8'($urandom_range(0, 255)));
      send_byte(buf_q[i], i == buf_q.size() - 1, CHK_PRED, '0);
    end
  endtask

  initial begin : main
    int         phase;
    int         sent;
    int         mid;
    logic [7:0] tgt;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = 8'd0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = 8'd0;
    in_ch.last_byte = 1'b0;
    cur_chk         = CHK_PRED;
    cur_exp         = '0;
    allow_idle      = 1'b1;
    fail_count      = 0;
    cycle_count     = 0;
    p_target        = 8'd0;
    clear_scan();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // directed: match on reset target, then a foreign type ends the scan
    add_row(ROW_BYTE, 8'h00, 1'b0, CHK_NONE, '0);
    add_row(ROW_BYTE, 8'h01, 1'b0, CHK_NONE, '0);
    add_row(ROW_BYTE, 8'hFF, 1'b0, CHK_RES, mk_res(8'hFF, 1'b1, 1'b0, ST_FOUND, 16'd0));
    add_row(ROW_BYTE, 8'h05, 1'b0, CHK_RES, mk_res(8'h00, 1'b0, 1'b1, ST_FOUND, 16'd1));
    // bytes after the scan finished are dropped
    add_row(ROW_BYTE, 8'hAA, 1'b0, CHK_NONE, '0);
    add_row(ROW_BYTE, 8'h55, 1'b1, CHK_NONE, '0);
    add_row(ROW_CFG,  8'hFF, 1'b0, CHK_NONE, '0);
    // skipped item, then zero-length matches only
    add_row(ROW_BYTE, 8'h01, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h02, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h12, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h34, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'hFF, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h00, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'hFF, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h00, 1'b1, CHK_RES, mk_res(8'h00, 1'b0, 1'b1, ST_NOTFOUND, 16'd0));
    // end on a type byte
    add_row(ROW_BYTE, 8'hFF, 1'b1, CHK_RES, mk_res(8'h00, 1'b0, 1'b1, ST_TRUNC, 16'd0));
    // end inside the value bytes
    add_row(ROW_BYTE, 8'hFF, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h03, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h80, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h7F, 1'b1, CHK_RES, mk_res(8'h7F, 1'b1, 1'b1, ST_TRUNC, 16'd2));
    // end on a nonzero length byte
    add_row(ROW_BYTE, 8'h00, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h10, 1'b1, CHK_RES, mk_res(8'h00, 1'b0, 1'b1, ST_TRUNC, 16'd0));
    // last value byte and end together
    add_row(ROW_BYTE, 8'hFF, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h01, 1'b0, CHK_PRED, '0);
    add_row(ROW_BYTE, 8'h00, 1'b1, CHK_RES, mk_res(8'h00, 1'b1, 1'b1, ST_FOUND, 16'd1));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) write_target(directed_rows[i].data);
      else send_byte(directed_rows[i].data, directed_rows[i].last,
                     directed_rows[i].chk, directed_rows[i].exp);
    end

    // random phases, extremes of the target first, last phase without idling
    for (phase = 0; phase < 5; phase++) begin
      if (phase == 0) tgt = 8'h00;
      else if (phase == 1) tgt = 8'hFF;
      else tgt = 8'($urandom_range(0, 255));
      write_target(tgt);
      sent = 0;
      while (sent < PHASE_BYTES) begin
        allow_idle = (phase != 4) && ($urandom_range(0, 3) != 0);
        make_buffer();
        mid = ($urandom_range(0, 5) == 0) ? $urandom_range(0, buf_q.size() - 1) : -1;
        send_buffer(mid);
        sent += buf_q.size();
      end
    end

    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (fail_count == 0) $display("tb passed");
    else $display("tb failed");
    $finish;
  end

endmodule
